FILE: design/iorb_pkg.sv
// Shared constants and types for the in-order release buffer.
`timescale 1ns / 1ps

package iorb_pkg;

    localparam int WINDOW       = 16;
    localparam int SEQ_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int SEQ_PORT_W = 16;
    localparam int PAY_PORT_W = 32;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int DIST_W = (SEQ_BITS > IDX_W + 1) ? SEQ_BITS : IDX_W + 1;

    localparam logic STATUS_RELEASED = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic                load;
        logic                from_ram;
        logic [SEQ_BITS-1:0] seq;
        logic                last;
        logic                status;
    } iorb_emit_t;

endpackage

FILE: design/in_order_release_buffer_top.sv
// Top level of the in-order release buffer: slot store, sequencer and output register.
`timescale 1ns / 1ps
// An in-order or rejected request shows its result in the cycle after acceptance.
// A request that is buffered gives no result and the next request may follow the next cycle.
// Each buffered request released behind an in-order one is read from the slot RAM, whose read
// is registered, and then emitted; the input is not ready until the whole run has drained.
// Reset (rst_n, asynchronous, active low) empties all slots and sets the expected number to 0.

module in_order_release_buffer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [iorb_pkg::SEQ_PORT_W-1:0] seq_id,
    input  logic [iorb_pkg::PAY_PORT_W-1:0] payload,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [iorb_pkg::PAY_PORT_W-1:0] out_payload,
    output logic [iorb_pkg::SEQ_PORT_W-1:0] out_seq_id,
    output logic                            last,
    output logic                            status
);

    iorb_pkg::iorb_emit_t                emit;
    logic                                out_free;
    logic                                ram_we;
    logic                                ram_re;
    logic [iorb_pkg::IDX_W-1:0]          ram_waddr;
    logic [iorb_pkg::IDX_W-1:0]          ram_raddr;
    logic [iorb_pkg::PAYLOAD_BITS-1:0]   ram_rdata;
    logic [iorb_pkg::PAYLOAD_BITS-1:0]   in_pay;

    logic                                out_valid_reg;
    logic [iorb_pkg::PAYLOAD_BITS-1:0]   out_pay_reg;
    logic [iorb_pkg::SEQ_BITS-1:0]       out_seq_reg;
    logic                                out_last_reg;
    logic                                out_status_reg;

    assign in_pay   = iorb_pkg::PAYLOAD_BITS'(payload);
    assign out_free = !out_valid_reg || out_ready;

    iorb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_seq    (iorb_pkg::SEQ_BITS'(seq_id)),
        .out_free  (out_free),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    iorb_ram #(
        .WIDTH (iorb_pkg::PAYLOAD_BITS),
        .DEPTH (iorb_pkg::WINDOW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_pay),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            out_pay_reg    <= emit.from_ram ? ram_rdata : in_pay;
            out_seq_reg    <= emit.seq;
            out_last_reg   <= emit.last;
            out_status_reg <= emit.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_payload = iorb_pkg::PAY_PORT_W'(out_pay_reg);
    assign out_seq_id  = iorb_pkg::SEQ_PORT_W'(out_seq_reg);
    assign last        = out_last_reg;
    assign status      = out_status_reg;

endmodule

FILE: design/iorb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module iorb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/iorb_ctrl.sv
// Sequencer of the release buffer: window check, slot valid bits and drain walk.
`timescale 1ns / 1ps

module iorb_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [iorb_pkg::SEQ_BITS-1:0]     in_seq,
    input  logic                              out_free,
    output iorb_pkg::iorb_emit_t              emit,
    output logic                              ram_we,
    output logic [iorb_pkg::IDX_W-1:0]        ram_waddr,
    output logic                              ram_re,
    output logic [iorb_pkg::IDX_W-1:0]        ram_raddr
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [iorb_pkg::SEQ_BITS-1:0]   next_exp_reg, next_exp_next;
    logic [iorb_pkg::IDX_W-1:0]      head_reg, head_next;
    logic [iorb_pkg::WINDOW-1:0]     valid_reg, valid_next;

    logic [iorb_pkg::SEQ_BITS-1:0]   seq_gap;
    logic                            in_window;
    logic [iorb_pkg::IDX_W:0]        slot_sum;
    logic [iorb_pkg::IDX_W-1:0]      slot_idx;
    logic [iorb_pkg::IDX_W-1:0]      head_inc;
    logic                            accept;

    // Shared arithmetic: distance to the expected number and the slot it maps to.
    assign seq_gap   = in_seq - next_exp_reg;
    assign in_window = iorb_pkg::DIST_W'(seq_gap) < iorb_pkg::DIST_W'(iorb_pkg::WINDOW);
    assign slot_sum  = {1'b0, head_reg} + (iorb_pkg::IDX_W + 1)'(seq_gap);
    assign slot_idx  = (slot_sum >= (iorb_pkg::IDX_W + 1)'(iorb_pkg::WINDOW))
                     ? iorb_pkg::IDX_W'(slot_sum - (iorb_pkg::IDX_W + 1)'(iorb_pkg::WINDOW))
                     : slot_sum[iorb_pkg::IDX_W-1:0];
    assign head_inc  = (head_reg == iorb_pkg::IDX_W'(iorb_pkg::WINDOW - 1))
                     ? '0 : head_reg + 1'b1;

    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign ram_waddr = slot_idx;
    assign ram_raddr = head_reg;
    assign ram_re    = (state_reg == ST_READ);

    always_comb
    begin
        state_next    = state_reg;
        next_exp_next = next_exp_reg;
        head_next     = head_reg;
        valid_next    = valid_reg;
        ram_we        = 1'b0;
        emit          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (seq_gap == '0)
                    begin
                        emit.load     = 1'b1;
                        emit.seq      = in_seq;
                        emit.status   = iorb_pkg::STATUS_RELEASED;
                        emit.last     = !valid_reg[head_inc];
                        next_exp_next = next_exp_reg + 1'b1;
                        head_next     = head_inc;
                        if (valid_reg[head_inc])
                        begin
                            state_next = ST_READ;
                        end
                    end
                    else if (in_window && !valid_reg[slot_idx])
                    begin
                        ram_we               = 1'b1;
                        valid_next[slot_idx] = 1'b1;
                    end
                    else
                    begin
                        emit.load   = 1'b1;
                        emit.seq    = in_seq;
                        emit.status = iorb_pkg::STATUS_REJECTED;
                        emit.last   = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit.load            = 1'b1;
                    emit.from_ram        = 1'b1;
                    emit.seq             = next_exp_reg;
                    emit.status          = iorb_pkg::STATUS_RELEASED;
                    emit.last            = !valid_reg[head_inc];
                    valid_next[head_reg] = 1'b0;
                    next_exp_next        = next_exp_reg + 1'b1;
                    head_next            = head_inc;
                    state_next           = valid_reg[head_inc] ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            next_exp_reg <= '0;
            head_reg     <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            next_exp_reg <= next_exp_next;
            head_reg     <= head_next;
            valid_reg    <= valid_next;
        end
    end

    // A new item never lands on a slot that still holds a buffered item.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !valid_reg[ram_waddr])
        else $error("write to an occupied slot");

    // The drain walk only reads slots that hold an item.
    a_read_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> valid_reg[head_reg])
        else $error("drain read of an empty slot");

    // Every read is followed by its emit step.
    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_EMIT))
        else $error("read not followed by emit");

    // A rejection is always the only, and therefore last, result.
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.load && emit.status == iorb_pkg::STATUS_REJECTED) |-> emit.last)
        else $error("rejection without last");

    // Items from the store leave only from the emit step, once the output frees.
    a_ram_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.load && emit.from_ram) |-> (state_reg == ST_EMIT) && out_free)
        else $error("stored item emitted outside the emit step");

endmodule
